FILE: hdl/sspq_pkg.sv
`timescale 1ns / 1ps
// Package for the stable sorted priority queue: sizes, codes and shared types.
// Used by the channel interfaces, the cell, the top level and the checker.

package sspq_pkg;

   localparam int DEPTH     = 16;
   localparam int TAG_BITS  = 16;
   localparam int PRIO_BITS = 16;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   typedef enum logic {
      ACTION_INSERT = 1'b0,
      ACTION_REMOVE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED  = 2'd0,
      STATUS_REMOVED   = 2'd1,
      STATUS_UNDERFLOW = 2'd2,
      STATUS_OVERFLOW  = 2'd3
   } status_type;

   typedef struct packed {
      logic [TAG_BITS-1:0]         tag;
      logic signed [PRIO_BITS-1:0] prio;
   } entry_type;

   // broadcast to every cell in the chain
   typedef struct packed {
      logic                        insert;
      logic                        remove;
      logic [TAG_BITS-1:0]         tag;
      logic signed [PRIO_BITS-1:0] prio;
   } cell_ctrl_type;

endpackage

FILE: hdl/sspq_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses.
// Depends on sspq_pkg for field widths.

interface sspq_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  action;
   logic [sspq_pkg::TAG_BITS-1:0]         item_tag;
   logic signed [sspq_pkg::PRIO_BITS-1:0] priority_req;

   modport source (output valid, output action, output item_tag, output priority_req,
                   input ready);
   modport sink   (input valid, input action, input item_tag, input priority_req,
                   output ready);
endinterface

interface sspq_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            status;
   logic [sspq_pkg::TAG_BITS-1:0]         out_tag;
   logic signed [sspq_pkg::PRIO_BITS-1:0] out_priority;
   logic [sspq_pkg::CNT_BITS-1:0]         occupancy;

   modport source (output valid, output status, output out_tag, output out_priority,
                   output occupancy, input ready);
   modport sink   (input valid, input status, input out_tag, input out_priority,
                   input occupancy, output ready);
endinterface

FILE: hdl/sspq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an entry, compares it with the new one,
// and takes the new entry or a neighbor's entry. Depends on sspq_pkg.

module sspq_cell (
   input  logic                    clock,
   input  sspq_pkg::cell_ctrl_type ctrl,
   input  logic                    occupied,
   input  logic                    left_displace,
   input  sspq_pkg::entry_type     left_entry,
   input  sspq_pkg::entry_type     right_entry,
   output logic                    displace,
   output sspq_pkg::entry_type     entry
);

   sspq_pkg::entry_type entry_ff;
   sspq_pkg::entry_type entry_in;

   // new entry lands ahead of this slot; equal priorities stay behind
   assign displace = !occupied || ($signed(entry_ff.prio) > $signed(ctrl.prio));
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (displace) begin
            if (left_displace) begin
               entry_in = left_entry;
            end else begin
               entry_in.tag  = ctrl.tag;
               entry_in.prio = ctrl.prio;
            end
         end
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: hdl/stable_sorted_priority_queue.sv
`timescale 1ns / 1ps
// Stable sorted priority queue, smallest priority first, up to DEPTH entries.
// Depends on sspq_pkg, sspq_req_if / sspq_rsp_if and sspq_cell.
//
// Usage:
//   req_ch carries one request per transaction: action (insert or remove head),
//   item_tag and priority_req. rsp_ch returns exactly one response per request:
//   status, the removed tag and priority (zero unless removed) and occupancy.
//   The response is registered and shows in the cycle after its request is
//   accepted. Throughput is one request per cycle while the receiver takes
//   responses, set by the row of cells, which all compare against the new
//   priority and shift in the same cycle. Equal priorities leave in arrival order.
//   Insert into a full queue is dropped with status overflow; remove from an
//   empty queue gives status underflow. Neither changes the contents.
//   Reset (synchronous, active high) empties the queue and drops any pending
//   response. When the receiver stalls, the response register holds its
//   transaction and req_ch.ready stays low until it is taken.

module stable_sorted_priority_queue (
   input logic         clock,
   input logic         reset,
   sspq_req_if.sink    req_ch,
   sspq_rsp_if.source  rsp_ch
);

   localparam int DEPTH    = sspq_pkg::DEPTH;
   localparam int CNT_BITS = sspq_pkg::CNT_BITS;

   logic [CNT_BITS-1:0]           count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   sspq_pkg::status_type          rsp_status_ff, rsp_status_in;
   sspq_pkg::entry_type           rsp_entry_ff, rsp_entry_in;
   logic [CNT_BITS-1:0]           rsp_count_ff;

   logic                          req_fire;
   logic                          is_remove;
   logic                          full;
   logic                          empty;
   sspq_pkg::cell_ctrl_type       ctrl;
   logic [DEPTH-1:0]              occupied;
   logic [DEPTH-1:0]              displace;
   sspq_pkg::entry_type           entries [DEPTH];

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign is_remove    = (req_ch.action == sspq_pkg::ACTION_REMOVE);
   assign full         = (count_ff == CNT_BITS'(DEPTH));
   assign empty        = (count_ff == '0);

   always_comb begin
      ctrl.insert = req_fire && !is_remove && !full;
      ctrl.remove = req_fire && is_remove && !empty;
      ctrl.tag    = req_ch.item_tag;
      ctrl.prio   = req_ch.priority_req;
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         assign occupied[i] = (count_ff > CNT_BITS'(i));
         if (i == 0) begin : g_head
            sspq_cell u_cell (
               .clock         (clock),
               .ctrl          (ctrl),
               .occupied      (occupied[i]),
               .left_displace (1'b0),
               .left_entry    (entries[i]),
               .right_entry   (entries[i+1]),
               .displace      (displace[i]),
               .entry         (entries[i])
            );
         end else if (i == DEPTH - 1) begin : g_tail
            sspq_cell u_cell (
               .clock         (clock),
               .ctrl          (ctrl),
               .occupied      (occupied[i]),
               .left_displace (displace[i-1]),
               .left_entry    (entries[i-1]),
               .right_entry   (entries[i]),
               .displace      (displace[i]),
               .entry         (entries[i])
            );
         end else begin : g_mid
            sspq_cell u_cell (
               .clock         (clock),
               .ctrl          (ctrl),
               .occupied      (occupied[i]),
               .left_displace (displace[i-1]),
               .left_entry    (entries[i-1]),
               .right_entry   (entries[i+1]),
               .displace      (displace[i]),
               .entry         (entries[i])
            );
         end
      end
   endgenerate

   always_comb begin
      count_in      = count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_entry_in = '0;
         if (is_remove) begin
            if (empty) begin
               rsp_status_in = sspq_pkg::STATUS_UNDERFLOW;
            end else begin
               rsp_status_in = sspq_pkg::STATUS_REMOVED;
               rsp_entry_in  = entries[0];
               count_in      = count_ff - 1'b1;
            end
         end else begin
            if (full) begin
               rsp_status_in = sspq_pkg::STATUS_OVERFLOW;
            end else begin
               rsp_status_in = sspq_pkg::STATUS_INSERTED;
               count_in      = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_entry_ff  <= rsp_entry_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.out_tag      = rsp_entry_ff.tag;
   assign rsp_ch.out_priority = rsp_entry_ff.prio;
   assign rsp_ch.occupancy    = rsp_count_ff;

endmodule

FILE: hdl/sspq_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the stable sorted priority queue, bound to the top level.
// Depends on sspq_pkg.

module sspq_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [1:0]                            rsp_status,
   input logic [sspq_pkg::TAG_BITS-1:0]         rsp_out_tag,
   input logic signed [sspq_pkg::PRIO_BITS-1:0] rsp_out_priority,
   input logic [sspq_pkg::CNT_BITS-1:0]         rsp_occupancy
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_out_tag)
         && $stable(rsp_out_priority) && $stable(rsp_occupancy))
      else $error("response changed while stalled");

   // every accepted request answers on the next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("missing response after accepted request");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sspq_pkg::STATUS_OVERFLOW |->
         rsp_occupancy == sspq_pkg::CNT_BITS'(sspq_pkg::DEPTH)
         && rsp_out_tag == '0 && rsp_out_priority == '0)
      else $error("bad overflow response");

   a_underflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sspq_pkg::STATUS_UNDERFLOW |->
         rsp_occupancy == '0 && rsp_out_tag == '0 && rsp_out_priority == '0)
      else $error("bad underflow response");

endmodule

bind stable_sorted_priority_queue sspq_checker u_sspq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_out_tag      (rsp_ch.out_tag),
   .rsp_out_priority (rsp_ch.out_priority),
   .rsp_occupancy    (rsp_ch.occupancy)
);
